### hw/rtl/lrsc_pkg.sv
// ----------------------------------------------------------------------------
// lrsc_pkg
// shared types and constants for the lr/sc reservation monitor
// ----------------------------------------------------------------------------
package lrsc_pkg;

    localparam int OP_W   = 3;
    localparam int HART_W = 3;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int WORD_W = 30;
    localparam int CNT_W  = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_LR         = 3'd0;
    localparam logic [OP_W-1:0] OP_SC         = 3'd1;
    localparam logic [OP_W-1:0] OP_STORE      = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_SELF = 3'd3;
    localparam logic [OP_W-1:0] OP_DEVICE     = 3'd4;

    // active hart count after reset
    localparam logic [CNT_W-1:0] ACTIVE_HARTS_RESET = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [HART_W-1:0] hart_id;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_value;
    } in_beat_t;

    typedef struct packed {
        logic              sc_failed;
        logic              commit_write;
        logic [WORD_W-1:0] commit_word_address;
        logic [DATA_W-1:0] commit_value;
    } out_beat_t;

endpackage

### hw/rtl/lr_sc_reservation_monitor.sv
// ----------------------------------------------------------------------------
// lr_sc_reservation_monitor
// per-hart word reservations for lr/sc, cleared by sc, clear-self, stores and device writes
// ----------------------------------------------------------------------------
//
//  channel  | signals                    | beat
//  ---------+----------------------------+------------------------------------
//  in       | in_valid, in_stall, in_data| one access (op, hart, addr, data)
//  out      | out_valid, out_stall,      | one result per access
//           | out_data                   |
//  cfg      | cfg_we, cfg_wdata          | active hart count, written any edge
//
//  one beat per cycle sustained while out_stall is low; each access passes
//  the input register, then the result register. all reservations are
//  compared in parallel in one pass. reset clears every reservation valid
//  bit and sets active_harts to 8. out_stall freezes a full result register
//  and, when the input register is full, backs up to in_stall in the same cycle.
//
module lr_sc_reservation_monitor #(
    parameter int HART_COUNT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lrsc_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lrsc_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lrsc_pkg::out_beat_t             out_data
);

    // configuration
    logic [lrsc_pkg::CNT_W-1:0] active_harts_reg;

    // input register
    logic               s1_valid_reg;
    logic               s1_valid_next;
    lrsc_pkg::in_beat_t s1_data_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    lrsc_pkg::out_beat_t out_data_reg;
    lrsc_pkg::out_beat_t out_data_next;

    // reservation state: valid bits reset, words are payload
    logic [HART_COUNT-1:0]         rsv_valid_reg;
    logic [HART_COUNT-1:0]         rsv_valid_next;
    logic [lrsc_pkg::WORD_W-1:0]   rsv_word_reg [HART_COUNT];

    // per-hart decode
    logic [lrsc_pkg::WORD_W-1:0] word;
    logic [HART_COUNT-1:0]       in_range;
    logic [HART_COUNT-1:0]       hart_sel;
    logic [HART_COUNT-1:0]       match_vec;
    logic                        live;
    logic                        own_hit;
    logic                        advance;
    logic                        fire;

    // result register moves when empty or taken downstream
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = advance && s1_valid_reg;
    assign in_stall = s1_valid_reg && !advance;

    assign word = s1_data_reg.address[lrsc_pkg::ADDR_W-1:2];

    // live hart: below both the configured count and the instance size
    assign live = ({29'd0, s1_data_reg.hart_id} < {28'd0, active_harts_reg})
               && ({29'd0, s1_data_reg.hart_id} < 32'(HART_COUNT));

    always_comb
    begin
        for (int h = 0; h < HART_COUNT; h++)
        begin
            in_range[h]  = 32'(h) < {28'd0, active_harts_reg};
            hart_sel[h]  = live && ({29'd0, s1_data_reg.hart_id} == 32'(h));
            match_vec[h] = rsv_valid_reg[h] && (rsv_word_reg[h] == word);
        end
    end

    // requester holds a reservation on this word
    assign own_hit = |(match_vec & hart_sel);

    // next reservation valid bits and result
    always_comb
    begin
        rsv_valid_next = rsv_valid_reg;
        out_data_next  = '0;
        case (s1_data_reg.operation)
            lrsc_pkg::OP_LR:
            begin
                rsv_valid_next = rsv_valid_reg | hart_sel;
            end
            lrsc_pkg::OP_SC:
            begin
                if (own_hit)
                begin
                    // success drops every active reservation on the word
                    rsv_valid_next                    = rsv_valid_reg & ~(match_vec & in_range);
                    out_data_next.commit_write        = 1'b1;
                    out_data_next.commit_word_address = word;
                    out_data_next.commit_value        = s1_data_reg.write_value;
                end
                else
                begin
                    rsv_valid_next          = rsv_valid_reg & ~hart_sel;
                    out_data_next.sc_failed = 1'b1;
                end
            end
            lrsc_pkg::OP_STORE:
            begin
                rsv_valid_next = rsv_valid_reg & ~(match_vec & in_range);
            end
            lrsc_pkg::OP_CLEAR_SELF:
            begin
                rsv_valid_next = rsv_valid_reg & ~hart_sel;
            end
            lrsc_pkg::OP_DEVICE:
            begin
                rsv_valid_next = rsv_valid_reg & ~in_range;
            end
            default:
            begin
                rsv_valid_next = rsv_valid_reg;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_harts_reg <= lrsc_pkg::ACTIVE_HARTS_RESET;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            rsv_valid_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_harts_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                rsv_valid_reg <= rsv_valid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
        for (int h = 0; h < HART_COUNT; h++)
        begin
            if (fire && (s1_data_reg.operation == lrsc_pkg::OP_LR) && hart_sel[h])
            begin
                rsv_word_reg[h] <= word;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result is never both a commit and a failure
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.sc_failed && out_data_reg.commit_write))
        else $error("sc result both failed and committed");

    // commit fields are zero outside a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.commit_write) |->
            (out_data_reg.commit_word_address == '0 && out_data_reg.commit_value == '0))
        else $error("commit fields set without commit");

    // load-reserved from a live hart leaves that hart reserved
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_data_reg.operation == lrsc_pkg::OP_LR) |=>
            ((rsv_valid_reg & $past(hart_sel)) == $past(hart_sel)))
        else $error("load-reserved did not set reservation");

    // device write leaves no active hart reserved
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_data_reg.operation == lrsc_pkg::OP_DEVICE) |=>
            ((rsv_valid_reg & $past(in_range)) == '0))
        else $error("device write left a reservation");

    // a successful store-conditional leaves nobody active reserved on that word
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_data_reg.operation == lrsc_pkg::OP_SC && own_hit) |=>
            ((rsv_valid_reg & $past(match_vec & in_range)) == '0))
        else $error("sc success kept a matching reservation");

endmodule

### test/tb_lr_sc_reservation_monitor.sv
// ----------------------------------------------------------------------------
// tb_lr_sc_reservation_monitor
// self-checking bench for the lr/sc reservation monitor: every accepted access
// beat is run through a local copy of the per-hart reservation table to get
// the expected result beat, and result beats are compared in order, field by
// field. directed accesses cover the corner cases, then random lr/sc-heavy
// traffic runs under several active hart counts with random input gaps and
// output stalls.
// ----------------------------------------------------------------------------

class reservation_scoreboard;

    lrsc_pkg::out_beat_t                expected_q[$];
    bit                                 rsv_valid[];
    logic [lrsc_pkg::WORD_W-1:0]        rsv_word[];
    int                                 hart_total;
    int                                 live_harts;
    int                                 errors;

    function new(int harts);
        hart_total = harts;
        rsv_valid  = new[harts];
        rsv_word   = new[harts];
        foreach (rsv_valid[h])
        begin
            rsv_valid[h] = 1'b0;
            rsv_word[h]  = '0;
        end
        errors = 0;
        set_active_harts(lrsc_pkg::ACTIVE_HARTS_RESET);
    endfunction

    // counts above the table size act as the table size
    function void set_active_harts(logic [lrsc_pkg::CNT_W-1:0] n);
        live_harts = (int'(n) > hart_total) ? hart_total : int'(n);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void drop_word(logic [lrsc_pkg::WORD_W-1:0] word);
        for (int h = 0; h < live_harts; h++)
            if (rsv_valid[h] && rsv_word[h] == word)
                rsv_valid[h] = 1'b0;
    endfunction

    function void note_access(lrsc_pkg::in_beat_t b);
        lrsc_pkg::out_beat_t         want;
        logic [lrsc_pkg::WORD_W-1:0] word;
        bit                          live;
        want = '0;
        word = b.address[lrsc_pkg::ADDR_W-1:2];
        live = int'(b.hart_id) < live_harts;
        case (b.operation)
            lrsc_pkg::OP_LR:
            begin
                if (live)
                begin
                    rsv_word[b.hart_id]  = word;
                    rsv_valid[b.hart_id] = 1'b1;
                end
            end
            lrsc_pkg::OP_SC:
            begin
                if (live && rsv_valid[b.hart_id] && rsv_word[b.hart_id] == word)
                begin
                    drop_word(word);
                    want.commit_write        = 1'b1;
                    want.commit_word_address = word;
                    want.commit_value        = b.write_value;
                end
                else
                begin
                    if (live)
                        rsv_valid[b.hart_id] = 1'b0;
                    want.sc_failed = 1'b1;
                end
            end
            lrsc_pkg::OP_STORE:
                drop_word(word);
            lrsc_pkg::OP_CLEAR_SELF:
            begin
                if (live)
                    rsv_valid[b.hart_id] = 1'b0;
            end
            lrsc_pkg::OP_DEVICE:
            begin
                for (int h = 0; h < live_harts; h++)
                    rsv_valid[h] = 1'b0;
            end
            default:
            begin
            end
        endcase
        expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function void check_result(lrsc_pkg::out_beat_t got);
        lrsc_pkg::out_beat_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $error("result beat with nothing expected: 0x%0h", got);
            return;
        end
        want = expected_q.pop_front();
        compare_field("sc_failed", want.sc_failed, got.sc_failed);
        compare_field("commit_write", want.commit_write, got.commit_write);
        compare_field("commit_word_address", want.commit_word_address,
                      got.commit_word_address);
        compare_field("commit_value", want.commit_value, got.commit_value);
    endfunction

endclass

module tb_lr_sc_reservation_monitor;

    timeunit 1ns;
    timeprecision 1ps;

    import lrsc_pkg::*;

    localparam int HARTS           = 8;
    localparam int POOL_SIZE       = 6;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 100000;

    // operation codes the block must ignore
    localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    in_beat_t            in_data;
    logic                out_valid;
    logic                out_stall;
    out_beat_t           out_data;

    reservation_scoreboard sb;

    int                  cycles;
    int                  burst_left;
    int                  gap;
    int                  cur_live;
    logic [ADDR_W-1:0]   last_lr_addr[HARTS];
    logic [ADDR_W-1:0]   addr_pool[POOL_SIZE];
    logic [CNT_W-1:0]    phase_counts[PHASES] = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd9, 4'd8};

    lr_sc_reservation_monitor #(
        .HART_COUNT (HARTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs or drops beats
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: stall pattern switches between randomly chosen modes
    // (free running, light, heavy, alternating)
    initial
    begin
        int mode;
        int run_len;
        out_stall = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(20, 80);
            repeat (run_len)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // every result beat taken at the edge is checked against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function automatic in_beat_t access(logic [OP_W-1:0] op, int hart,
                                        logic [ADDR_W-1:0] addr,
                                        logic [DATA_W-1:0] value);
        in_beat_t b;
        b.operation   = op;
        b.hart_id     = HART_W'(hart);
        b.address     = addr;
        b.write_value = value;
        return b;
    endfunction

    // low two bits are noise, the word part comes from a small pool so
    // reservations actually collide
    function automatic logic [ADDR_W-1:0] pool_addr();
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ADDR_W'($urandom_range(0, 3));
    endfunction

    // mostly lr followed by sc on the reserved word, with stores, clears and
    // device writes mixed in to break reservations; a few ignored codes too
    function automatic in_beat_t random_access();
        in_beat_t b;
        int       pick;
        int       hart;
        pick = $urandom_range(0, 99);
        if (cur_live > 0 && $urandom_range(0, 3) != 0)
            hart = $urandom_range(0, cur_live - 1);
        else
            hart = $urandom_range(0, HARTS - 1);
        b = access(OP_LR, hart, pool_addr(), $urandom());
        if (pick < 30)
            b.operation = OP_LR;
        else if (pick < 60)
        begin
            b.operation = OP_SC;
            if ($urandom_range(0, 3) != 0)
                b.address = last_lr_addr[hart] ^ ADDR_W'($urandom_range(0, 3));
        end
        else if (pick < 75)
        begin
            b.operation = OP_STORE;
            if ($urandom_range(0, 1) == 0)
                b.address = last_lr_addr[$urandom_range(0, HARTS - 1)];
        end
        else if (pick < 85)
            b.operation = OP_CLEAR_SELF;
        else if (pick < 92)
            b.operation = OP_DEVICE;
        else if (pick < 96)
        begin
            b.operation = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            b.address   = $urandom();
        end
        else
        begin
            // fully random address, almost always a miss
            b.operation = ($urandom_range(0, 1) == 0) ? OP_SC : OP_STORE;
            b.address   = $urandom();
        end
        return b;
    endfunction

    // sends one access beat; called at a falling edge and returns at one.
    // the sender runs in bursts with random gaps between them, and valid
    // stays high across back-to-back beats
    task automatic send_access(input in_beat_t b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_access(b);
        if (b.operation == OP_LR)
            last_lr_addr[b.hart_id] = b.address;
        @(negedge clk);
    endtask

    // register write only with the block drained and the two-stage pipeline
    // left idle
    task automatic write_hart_count(input logic [CNT_W-1:0] n);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        sb.set_active_harts(n);
        cur_live = (int'(n) > HARTS) ? HARTS : int'(n);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        cur_live   = HARTS;
        foreach (last_lr_addr[h])
            last_lr_addr[h] = '0;
        sb = new(HARTS);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, all eight harts active after reset ----
        // reserve on every hart first so no reservation word is ever
        // compared before it has been written
        send_access(access(OP_LR, 0, 32'h0000_0000, 32'h0000_0000));
        send_access(access(OP_LR, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_access(access(OP_LR, 2, 32'h0000_2000, 32'h1111_1111));
        send_access(access(OP_LR, 3, 32'h0000_2002, 32'h2222_2222));
        send_access(access(OP_LR, 4, 32'h0000_3000, 32'h3333_3333));
        send_access(access(OP_LR, 5, 32'h0000_4000, 32'h4444_4444));
        send_access(access(OP_LR, 6, 32'h0000_5000, 32'h5555_5555));
        send_access(access(OP_LR, 7, 32'h0000_6000, 32'h6666_6666));
        // sc success on word zero, low byte bits ignored, then retry fails
        send_access(access(OP_SC, 0, 32'h0000_0003, 32'hFFFF_FFFF));
        send_access(access(OP_SC, 0, 32'h0000_0000, 32'h0000_0000));
        // sc success on the top word
        send_access(access(OP_SC, 1, 32'hFFFF_FFFC, 32'h0000_0000));
        // two harts on one word: the winner clears the other
        send_access(access(OP_SC, 2, 32'h0000_2001, 32'hA5A5_A5A5));
        send_access(access(OP_SC, 3, 32'h0000_2000, 32'h5A5A_5A5A));
        // wrong word fails and drops the reservation
        send_access(access(OP_SC, 4, 32'h0000_3004, 32'h1234_5678));
        send_access(access(OP_SC, 4, 32'h0000_3000, 32'h1234_5678));
        // plain store breaks a reservation regardless of hart id
        send_access(access(OP_STORE, 0, 32'h0000_4003, 32'hDEAD_BEEF));
        send_access(access(OP_SC, 5, 32'h0000_4000, 32'hDEAD_BEEF));
        // clear self
        send_access(access(OP_CLEAR_SELF, 6, 32'h0000_0000, 32'h0000_0000));
        send_access(access(OP_SC, 6, 32'h0000_5000, 32'h0BAD_F00D));
        // device write drops everything
        send_access(access(OP_DEVICE, 3, 32'h0000_0000, 32'h0000_0000));
        send_access(access(OP_SC, 7, 32'h0000_6000, 32'hCAFE_F00D));
        // ignored operation codes give an all-zero result
        send_access(access(OP_RSVD_LO, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_access(access(OP_RSVD_MID, 0, 32'h0000_6000, 32'h0000_0000));
        send_access(access(OP_RSVD_HI, 5, 32'h8000_0000, 32'h8000_0001));
        send_access(access(OP_LR, 7, 32'h0000_7000, 32'h0000_0000));

        // ---- random part, one active hart count per phase ----
        // includes zero harts, one hart, a mid value and counts above the
        // table size; reservations of harts outside the count must survive
        phase_counts[4] = CNT_W'($urandom_range(1, HARTS));
        for (int p = 0; p < PHASES; p++)
        begin
            write_hart_count(phase_counts[p]);
            foreach (addr_pool[i])
                addr_pool[i] = $urandom();
            repeat (ITEMS_PER_PHASE)
                send_access(random_access());
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
